@@ sv/mswr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswr_pkg
// Shared types, codes and helpers for the max stack with remove-maximum.
// ----------------------------------------------------------------------------
package mswr_pkg;

    localparam int DATA_W     = 32;
    localparam int OCC_W      = 7;
    localparam int MODE_W     = 2;
    localparam int MSWR_DEPTH = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_PEEK   = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_REPORT = 1'b1
    } state_t;

    // Command broadcast to every cell of the row, already qualified by the
    // accepted transaction.
    typedef struct packed {
        logic push;
        logic remove;
    } cell_cmd_t;

    function automatic logic signed [DATA_W-1:0] smax(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        smax = (b > a) ? b : a;
    endfunction

endpackage

@@ sv/mswr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswr_cell
// One stack slot: holds its value and the prefix maximum of all slots at or
// below it, and takes part in the shift and the prefix-maximum wave.
// ----------------------------------------------------------------------------
module mswr_cell
    import mswr_pkg::*;
#(
    parameter bit FIRST = 1'b0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic signed [DATA_W-1:0] max_now,
    input  logic                     slot_valid,
    input  logic                     at_count,
    input  logic                     shift_ok,
    input  logic signed [DATA_W-1:0] prev_pmax,
    input  logic                     prev_stale,
    input  logic signed [DATA_W-1:0] next_val,
    output logic signed [DATA_W-1:0] val,
    output logic signed [DATA_W-1:0] pmax,
    output logic                     stale
);

    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] pmax_reg, pmax_next;
    logic                     stale_reg, stale_next;
    logic                     mark;
    logic                     shift;

    // The deepest maximum is where the prefix maximum first reaches it.
    assign mark  = slot_valid && (pmax_reg == max_now) && (FIRST || (prev_pmax != max_now));
    assign shift = cmd.remove && shift_ok && (pmax_reg == max_now);

    always_comb
    begin
        val_next   = val_reg;
        pmax_next  = pmax_reg;
        stale_next = stale_reg;
        if (cmd.push && at_count)
        begin
            val_next  = push_value;
            pmax_next = FIRST ? push_value : smax(prev_pmax, push_value);
        end
        else if (shift)
        begin
            val_next = next_val;
            if (mark)
            begin
                pmax_next  = FIRST ? next_val : smax(prev_pmax, next_val);
                stale_next = 1'b0;
            end
            else
            begin
                stale_next = 1'b1;
            end
        end
        else if (stale_reg && !prev_stale)
        begin
            // The wave front: the neighbor below is up to date again.
            pmax_next  = FIRST ? val_reg : smax(prev_pmax, val_reg);
            stale_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= 1'b0;
        end
        else
        begin
            stale_reg <= stale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        pmax_reg <= pmax_next;
    end

    assign val   = val_reg;
    assign pmax  = pmax_reg;
    assign stale = stale_reg;

endmodule

@@ sv/mswr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswr_ctrl
// Sequencer, fill count and output register of the max stack.
// ----------------------------------------------------------------------------
module mswr_ctrl
    import mswr_pkg::*;
#(
    parameter int DEPTH = MSWR_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [MODE_W-1:0]        mode,
    input  logic                     any_stale,
    input  logic signed [DATA_W-1:0] top_sel,
    input  logic signed [DATA_W-1:0] max_sel,
    output cell_cmd_t                cmd,
    output logic [CNT_W-1:0]         count,
    output logic signed [DATA_W-1:0] max_now,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] top_value,
    output logic signed [DATA_W-1:0] max_value,
    output logic                     stack_empty,
    output logic [OCC_W-1:0]         occupancy,
    output logic                     dropped
);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic signed [DATA_W-1:0] cur_max_reg, cur_max_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] top_value_reg, max_value_reg;
    logic                     empty_reg, drop_out_reg;
    logic [OCC_W-1:0]         occ_reg;
    logic                     accept;
    logic                     load;
    logic                     full;
    logic                     none_held;
    mode_t                    op;

    assign op        = mode_t'(mode);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign none_held = (count_reg == '0);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_REPORT;
            ST_REPORT: if (load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output logic of the state machine.
    always_comb
    begin
        in_stall = 1'b1;
        accept   = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            ST_REPORT:
            begin
                load = !any_stale && (!out_valid_reg || !out_stall);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            dropped_next = 1'b0;
            unique case (op)
                MODE_PUSH:
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_POP:
                begin
                    if (!none_held) count_next = count_reg - 1'b1;
                end
                MODE_REMOVE:
                begin
                    if (!none_held)
                    begin
                        cmd.remove = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                MODE_PEEK: ;
                default: ;
            endcase
        end
    end

    assign cur_max_next = load ? max_sel : cur_max_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load) out_valid_next = 1'b1;
        else if (!out_stall) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_max_reg <= cur_max_next;
        if (load)
        begin
            top_value_reg <= none_held ? '0 : top_sel;
            max_value_reg <= none_held ? '0 : max_sel;
            empty_reg     <= none_held;
            occ_reg       <= OCC_W'(count_reg);
            drop_out_reg  <= dropped_reg;
        end
    end

    assign count       = count_reg;
    assign max_now     = cur_max_reg;
    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign max_value   = max_value_reg;
    assign stack_empty = empty_reg;
    assign occupancy   = occ_reg;
    assign dropped     = drop_out_reg;

endmodule

@@ sv/max_stack_with_remove_max.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_stack_with_remove_max
// Push, pop and peek: the result is registered once the transaction is taken
// and the output register is free; no other transaction is taken meanwhile.
// Remove-maximum: the result also waits for the prefix-maximum wave, which
// moves one cell per cycle up the row from the removed entry to the top.
// One transaction is in flight at a time; a new one is taken the cycle after
// the result loads. Reset empties the stack; slot contents are not cleared.
// ----------------------------------------------------------------------------
module max_stack_with_remove_max
    import mswr_pkg::*;
#(
    parameter int DEPTH = MSWR_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] top_value,
    output logic signed [DATA_W-1:0] max_value,
    output logic                     stack_empty,
    output logic [OCC_W-1:0]         occupancy,
    output logic                     dropped
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_cmd_t                cmd;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] max_now;
    logic signed [DATA_W-1:0] val_arr  [DEPTH];
    logic signed [DATA_W-1:0] pmax_arr [DEPTH];
    logic                     stale_arr[DEPTH];
    logic [DATA_W-1:0]        top_part [DEPTH];
    logic [DATA_W-1:0]        max_part [DEPTH];
    logic signed [DATA_W-1:0] top_sel;
    logic signed [DATA_W-1:0] max_sel;
    logic                     any_stale;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     is_top;
        logic signed [DATA_W-1:0] prev_pmax;
        logic                     prev_stale;
        logic signed [DATA_W-1:0] next_val;

        assign is_top     = (count == CNT_W'(i + 1));
        assign prev_pmax  = (i == 0) ? '0 : pmax_arr[(i == 0) ? 0 : i - 1];
        assign prev_stale = (i == 0) ? 1'b0 : stale_arr[(i == 0) ? 0 : i - 1];
        assign next_val   = (i == DEPTH - 1) ? '0 : val_arr[(i == DEPTH - 1) ? i : i + 1];

        mswr_cell #(
            .FIRST(i == 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .push_value (push_value),
            .max_now    (max_now),
            .slot_valid (count > CNT_W'(i)),
            .at_count   (count == CNT_W'(i)),
            .shift_ok   (count > CNT_W'(i + 1)),
            .prev_pmax  (prev_pmax),
            .prev_stale (prev_stale),
            .next_val   (next_val),
            .val        (val_arr[i]),
            .pmax       (pmax_arr[i]),
            .stale      (stale_arr[i])
        );

        assign top_part[i] = is_top ? val_arr[i] : '0;
        assign max_part[i] = is_top ? pmax_arr[i] : '0;
    end

    // At most one cell flags itself as the top, so an OR gathers its fields.
    always_comb
    begin
        logic [DATA_W-1:0] t_acc;
        logic [DATA_W-1:0] m_acc;
        logic              s_acc;
        t_acc = '0;
        m_acc = '0;
        s_acc = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            t_acc = t_acc | top_part[i];
            m_acc = m_acc | max_part[i];
            s_acc = s_acc | stale_arr[i];
        end
        top_sel   = t_acc;
        max_sel   = m_acc;
        any_stale = s_acc;
    end

    mswr_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .any_stale   (any_stale),
        .top_sel     (top_sel),
        .max_sel     (max_sel),
        .cmd         (cmd),
        .count       (count),
        .max_now     (max_now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_value   (top_value),
        .max_value   (max_value),
        .stack_empty (stack_empty),
        .occupancy   (occupancy),
        .dropped     (dropped)
    );

endmodule

@@ sv/mswr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswr_checker
// Port-level checks of the max stack, bound to the top level.
// ----------------------------------------------------------------------------
module mswr_checker
    import mswr_pkg::*;
#(
    parameter int DEPTH = MSWR_DEPTH
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [DATA_W-1:0] top_value,
    input logic signed [DATA_W-1:0] max_value,
    input logic                     stack_empty,
    input logic [OCC_W-1:0]         occupancy,
    input logic                     dropped
);

    // Only one transaction is in flight, so the input is held off right after one.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a transaction was in flight");

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(top_value)
            && $stable(max_value) && $stable(occupancy) && $stable(dropped))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stack_empty |-> top_value == '0 && max_value == '0
            && occupancy == '0)
        else $error("empty result with nonzero fields");

    a_max_ge_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stack_empty |-> max_value >= top_value && occupancy != '0)
        else $error("maximum below top value");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> occupancy == OCC_W'(DEPTH) && !stack_empty)
        else $error("dropped push while not full");

endmodule

bind max_stack_with_remove_max mswr_checker #(.DEPTH(DEPTH)) u_mswr_checker (.*);

@@ test/tb_max_stack_with_remove_max.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_stack_with_remove_max
// Self-checking bench for the bounded max stack with remove-maximum. A short
// table of hand-picked operations runs first, then phases of random traffic
// that fill the stack, drain it and mix both. Every accepted transaction is
// run through a shadow stack, and each report from the block is compared
// field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module tb_max_stack_with_remove_max
    import mswr_pkg::*;
();

    localparam int RANDOM_ITEMS = 1425;
    localparam int PHASE_LEN    = 150;
    localparam int QUIESCE_AT   = 700;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_v;
        logic signed [DATA_W-1:0] max_v;
        logic                     empty;
        logic [OCC_W-1:0]         occ;
        logic                     drop;
    } stack_report_t;

    typedef struct packed {
        mode_t             op;
        logic [DATA_W-1:0] value;
        logic              typed;
        stack_report_t     want;
    } stim_row_t;

    localparam stack_report_t EMPTY_REPORT =
        '{top_v: '0, max_v: '0, empty: 1'b1, occ: '0, drop: 1'b0};
    localparam stack_report_t NO_CHECK = '0;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] push_value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] max_value;
    logic                     stack_empty;
    logic [OCC_W-1:0]         occupancy;
    logic                     dropped;

    // Shadow copy of the stack: slot 0 is the oldest entry.
    logic signed [DATA_W-1:0] shadow [MSWR_DEPTH];
    int                       shadow_fill = 0;

    stack_report_t report_q [$];

    int mismatch_count  = 0;
    int reports_checked = 0;
    int items_sent      = 0;
    int full_drops      = 0;
    int empty_takes     = 0;
    int peak_fill       = 0;

    max_stack_with_remove_max #(
        .DEPTH(MSWR_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .push_value(push_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .top_value(top_value),
        .max_value(max_value),
        .stack_empty(stack_empty),
        .occupancy(occupancy),
        .dropped(dropped)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Ties go to the deepest entry: only a strictly larger value moves the pick.
    function automatic int deepest_max_slot();
        int best;
        best = 0;
        for (int i = 1; i < shadow_fill; i++)
            if (shadow[i] > shadow[best])
                best = i;
        return best;
    endfunction

    function automatic stack_report_t stack_apply(input mode_t op,
                                                  input logic [DATA_W-1:0] value);
        stack_report_t r;
        int gone;
        r.drop = 1'b0;
        case (op)
            MODE_PUSH:
            begin
                if (shadow_fill < MSWR_DEPTH)
                begin
                    shadow[shadow_fill] = value;
                    shadow_fill++;
                end
                else
                    r.drop = 1'b1;
            end
            MODE_POP:
            begin
                if (shadow_fill > 0)
                    shadow_fill--;
            end
            MODE_REMOVE:
            begin
                if (shadow_fill > 0)
                begin
                    gone = deepest_max_slot();
                    for (int i = gone; i + 1 < shadow_fill; i++)
                        shadow[i] = shadow[i + 1];
                    shadow_fill--;
                end
            end
            default:
            begin
            end
        endcase
        if (shadow_fill == 0)
        begin
            r.top_v = '0;
            r.max_v = '0;
            r.empty = 1'b1;
        end
        else
        begin
            r.top_v = shadow[shadow_fill - 1];
            r.max_v = shadow[deepest_max_slot()];
            r.empty = 1'b0;
        end
        r.occ = shadow_fill[OCC_W-1:0];
        return r;
    endfunction

    // Offers one transaction after an optional gap, holds it until the block
    // takes it, then books the report it must produce. With settle set, the
    // sender first waits until every outstanding report has come back.
    task automatic take_item(input mode_t op, input logic [DATA_W-1:0] value,
                             input logic typed, input stack_report_t want,
                             input int gap, input bit settle);
        stack_report_t got;
        if (gap > 0 || settle)
        begin
            in_valid <= 1'b0;
            if (settle)
            begin
                wait (report_q.size() == 0);
                @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        push_value <= value;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        if (shadow_fill == 0 && (op == MODE_POP || op == MODE_REMOVE))
            empty_takes++;
        got = stack_apply(op, value);
        if (got.drop)
            full_drops++;
        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
        report_q.push_back(typed ? want : got);
        items_sent++;
    endtask

    always @(posedge clk)
    begin : check_reports
        stack_report_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (report_q.size() == 0)
                flag_mismatch($sformatf("report with none outstanding: top %0d occupancy %0d",
                                        top_value, occupancy));
            else
            begin
                want = report_q.pop_front();
                reports_checked++;
                if (top_value !== want.top_v)
                    flag_mismatch($sformatf("report %0d top_value %0d, want %0d",
                                            reports_checked, top_value, want.top_v));
                if (max_value !== want.max_v)
                    flag_mismatch($sformatf("report %0d max_value %0d, want %0d",
                                            reports_checked, max_value, want.max_v));
                if (stack_empty !== want.empty)
                    flag_mismatch($sformatf("report %0d stack_empty %b, want %b",
                                            reports_checked, stack_empty, want.empty));
                if (occupancy !== want.occ)
                    flag_mismatch($sformatf("report %0d occupancy %0d, want %0d",
                                            reports_checked, occupancy, want.occ));
                if (dropped !== want.drop)
                    flag_mismatch($sformatf("report %0d dropped %b, want %b",
                                            reports_checked, dropped, want.drop));
            end
        end
    end

    // Result side: a random stall before each transaction, quiet stretches
    // with no stall, and two long holds that back the block up.
    initial
    begin : drain_reports
        int hold;
        int taken;
        taken     = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == 300 || taken == 1000)
                hold = LONG_HOLD;
            else if ((taken / 120) % 5 == 4)
                hold = 0;
            else
                hold = $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin : run_stimulus
        stim_row_t         directed_ops [24];
        mode_t             op;
        logic [DATA_W-1:0] value;
        int                kind;
        int                pick;
        int                push_cut;
        int                pop_cut;
        int                remove_cut;
        int                gap;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_PEEK;
        push_value = '0;

        directed_ops = '{
            // Everything on an empty stack reports zeros and changes nothing.
            '{MODE_PEEK,   32'h0000_0000, 1'b1, EMPTY_REPORT},
            '{MODE_POP,    32'h1234_5678, 1'b1, EMPTY_REPORT},
            '{MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, EMPTY_REPORT},
            '{MODE_PUSH,   32'h8000_0000, 1'b1,
              '{32'h8000_0000, 32'h8000_0000, 1'b0, 7'd1, 1'b0}},
            '{MODE_PUSH,   32'h7FFF_FFFF, 1'b1,
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 7'd2, 1'b0}},
            '{MODE_PUSH,   32'h0000_0000, 1'b0, NO_CHECK},
            '{MODE_PUSH,   32'hFFFF_FFFF, 1'b0, NO_CHECK},
            // A second copy of the largest value: removal must take the older.
            '{MODE_PUSH,   32'h7FFF_FFFF, 1'b0, NO_CHECK},
            '{MODE_REMOVE, 32'h0000_0000, 1'b0, NO_CHECK},
            '{MODE_PEEK,   32'h5555_5555, 1'b0, NO_CHECK},
            '{MODE_REMOVE, 32'hAAAA_AAAA, 1'b0, NO_CHECK},
            '{MODE_POP,    32'h0000_0000, 1'b0, NO_CHECK},
            '{MODE_POP,    32'h0000_0000, 1'b0, NO_CHECK},
            '{MODE_POP,    32'h0000_0000, 1'b1, EMPTY_REPORT},
            '{MODE_PUSH,   32'h0000_0009, 1'b1,
              '{32'h0000_0009, 32'h0000_0009, 1'b0, 7'd1, 1'b0}},
            // Maximum just below the top, then maximum at the top.
            '{MODE_PUSH,   32'h0000_0001, 1'b0, NO_CHECK},
            '{MODE_REMOVE, 32'h0000_0000, 1'b0, NO_CHECK},
            '{MODE_PUSH,   32'h0000_0009, 1'b0, NO_CHECK},
            '{MODE_REMOVE, 32'h0000_0000, 1'b0, NO_CHECK},
            '{MODE_PUSH,   32'h0000_0001, 1'b0, NO_CHECK},
            '{MODE_PUSH,   32'h0000_0001, 1'b0, NO_CHECK},
            '{MODE_REMOVE, 32'h0000_0000, 1'b0, NO_CHECK},
            '{MODE_PEEK,   32'h0000_0000, 1'b0, NO_CHECK},
            '{MODE_POP,    32'hFFFF_FFFF, 1'b0, NO_CHECK}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
            take_item(directed_ops[i].op, directed_ops[i].value, directed_ops[i].typed,
                      directed_ops[i].want, $urandom_range(0, 14), 1'b0);

        // Phases rotate between filling, draining and a mix, so the stack
        // runs into both its full and its empty ends many times.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = (n / PHASE_LEN) % 3;
            if (kind == 0)
            begin
                push_cut   = 75;
                pop_cut    = 80;
                remove_cut = 92;
            end
            else if (kind == 1)
            begin
                push_cut   = 20;
                pop_cut    = 55;
                remove_cut = 90;
            end
            else
            begin
                push_cut   = 45;
                pop_cut    = 62;
                remove_cut = 90;
            end
            pick = $urandom_range(0, 99);
            if (pick < push_cut)
                op = MODE_PUSH;
            else if (pick < pop_cut)
                op = MODE_POP;
            else if (pick < remove_cut)
                op = MODE_REMOVE;
            else
                op = MODE_PEEK;

            // Small values make ties for the maximum common.
            case ($urandom_range(0, 9))
                0: value = 32'h7FFF_FFFF;
                1: value = 32'h8000_0000;
                2, 3, 4: value = $urandom_range(0, 8) - 4;
                default: value = $urandom;
            endcase

            gap = ((n / PHASE_LEN) % 4 == 2) ? 0 : $urandom_range(0, 14);
            take_item(op, value, 1'b0, NO_CHECK, gap, n == 0 || n == QUIESCE_AT);
        end

        in_valid <= 1'b0;
        wait (report_q.size() == 0);
        repeat (2 * MSWR_DEPTH + 8) @(posedge clk);

        $display("Covered %0d stack transactions (%0d from the directed table), %0d reports checked, peak fill %0d of %0d.",
                 items_sent, $size(directed_ops), reports_checked, peak_fill, MSWR_DEPTH);
        $display("Pushes refused when full: %0d; pops or removes when empty: %0d; mismatches: %0d.",
                 full_drops, empty_takes, mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : watchdog
        #(20_000_000);
        $display("Timeout with %0d reports outstanding after %0d transactions",
                 report_q.size(), items_sent);
        $display("Some tests failed");
        $finish;
    end

endmodule
